// File: rtl/ttlcpu_pkg.sv
// shared types, codes and a helper function for the ttl cpu cycle block
package ttlcpu_pkg;

   // default ram address width (32K or 64K ram)
   localparam int RAM_ADDR_BITS_DEF = 16;

   // address masks for the two memory modes, and the page mask for jumps
   localparam logic [15:0] MASK_32K  = 16'h7FFF;
   localparam logic [15:0] MASK_64K  = 16'hFFFF;
   localparam logic [15:0] PAGE_MASK = 16'hFF00;

   // bits of the out register
   localparam int HSYNC_BIT = 6;
   localparam int VSYNC_BIT = 7;

   // item kinds
   localparam logic CMD_TICK  = 1'b0;
   localparam logic CMD_HOST  = 1'b1;

   // alu / instruction codes, ir[7:5]
   localparam logic [2:0] INS_LD  = 3'd0;
   localparam logic [2:0] INS_AND = 3'd1;
   localparam logic [2:0] INS_OR  = 3'd2;
   localparam logic [2:0] INS_XOR = 3'd3;
   localparam logic [2:0] INS_ADD = 3'd4;
   localparam logic [2:0] INS_SUB = 3'd5;
   localparam logic [2:0] INS_ST  = 3'd6;
   localparam logic [2:0] INS_JMP = 3'd7;

   // addressing modes, ir[4:2]
   localparam logic [2:0] MODE_D_AC    = 3'd0;
   localparam logic [2:0] MODE_X_AC    = 3'd1;
   localparam logic [2:0] MODE_YD_AC   = 3'd2;
   localparam logic [2:0] MODE_YX_AC   = 3'd3;
   localparam logic [2:0] MODE_D_X     = 3'd4;
   localparam logic [2:0] MODE_D_Y     = 3'd5;
   localparam logic [2:0] MODE_D_OUT   = 3'd6;
   localparam logic [2:0] MODE_YXI_OUT = 3'd7;

   // bus sources, ir[1:0]
   localparam logic [1:0] BUS_D   = 2'd0;
   localparam logic [1:0] BUS_RAM = 2'd1;
   localparam logic [1:0] BUS_AC  = 2'd2;
   localparam logic [1:0] BUS_IN  = 2'd3;

   // architectural register set
   typedef struct packed {
      logic [15:0] pc;
      logic [7:0]  ir;
      logic [7:0]  dr;
      logic [7:0]  ac;
      logic [7:0]  x;
      logic [7:0]  y;
      logic [7:0]  out;
      logic [7:0]  xout;
   } arch_type;

   // status flags of one executed item
   typedef struct packed {
      logic hsync_rise;
      logic vsync_fall;
   } flags_type;

   // 16-bit data address of an instruction, before the memory mode mask
   function automatic logic [15:0] agen(input logic [7:0] ir, input logic [7:0] dr,
                                        input logic [7:0] x, input logic [7:0] y);
      logic [7:0] lo;
      logic [7:0] hi;
      lo = dr;
      hi = 8'h00;
      if (ir[7:5] != INS_JMP) begin
         unique case (ir[4:2])
            MODE_X_AC:    lo = x;
            MODE_YD_AC:   hi = y;
            MODE_YX_AC:   begin
               lo = x;
               hi = y;
            end
            MODE_YXI_OUT: begin
               lo = x;
               hi = y;
            end
            default:      ;
         endcase
      end
      return {hi, lo};
   endfunction

endpackage

// File: rtl/ttlcpu_ram.sv
// main ram: one write port, one read port with registered read data
module ttlcpu_ram
   import ttlcpu_pkg::*;
#(
   parameter int ADDR_BITS = RAM_ADDR_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [7:0]           wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [7:0]           rd_data
);

   logic [7:0] mem_ff [2**ADDR_BITS];
   logic [7:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, old data on a same-address write
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/ttlcpu_exec.sv
// execute stage: decode, bus select, alu, register writes and next pc
module ttlcpu_exec
   import ttlcpu_pkg::*;
(
   input  arch_type   st,
   input  logic       cmd,
   input  logic [7:0] rom_instr,
   input  logic [7:0] rom_operand,
   input  logic [7:0] in_port,
   input  logic [7:0] host_data,
   input  logic [7:0] ram_rd,
   output arch_type   nx,
   output flags_type  flags,
   output logic       wr_en,
   output logic [7:0] wr_data
);

   logic [2:0] ins;
   logic [2:0] mode;
   logic [1:0] bus;
   logic       is_st;
   logic       is_jmp;
   logic [7:0] bval;
   logic [7:0] alu;
   logic [1:0] cond;
   logic       taken;
   arch_type   tk;

   assign ins    = st.ir[7:5];
   assign mode   = st.ir[4:2];
   assign bus    = st.ir[1:0];
   assign is_st  = (ins == INS_ST);
   assign is_jmp = (ins == INS_JMP);

   // bus source
   always_comb begin
      unique case (bus)
         BUS_D:   bval = st.dr;
         BUS_RAM: bval = is_st ? 8'h00 : ram_rd;
         BUS_AC:  bval = st.ac;
         BUS_IN:  bval = in_port;
         default: bval = st.dr;
      endcase
   end

   // alu
   always_comb begin
      unique case (ins)
         INS_LD:  alu = bval;
         INS_AND: alu = st.ac & bval;
         INS_OR:  alu = st.ac | bval;
         INS_XOR: alu = st.ac ^ bval;
         INS_ADD: alu = st.ac + bval;
         INS_SUB: alu = st.ac - bval;
         INS_ST:  alu = st.ac;
         default: alu = 8'h00 - st.ac;
      endcase
   end

   // branch condition from ac sign and zero
   assign cond  = {(st.ac == 8'h00), st.ac[7]};
   assign taken = ((({1'b0, mode} >> cond) & 4'd1) != 4'd0);

   // register writes and next pc for a clock tick
   always_comb begin
      tk    = st;
      tk.pc = st.pc + 16'd1;
      if (!is_jmp) begin
         unique case (mode)
            MODE_D_X:     tk.x = alu;
            MODE_D_Y:     tk.y = alu;
            MODE_D_OUT:   begin
               if (!is_st) tk.out = alu;
            end
            MODE_YXI_OUT: begin
               if (!is_st) tk.out = alu;
               tk.x = st.x + 8'd1;
            end
            default:      begin
               if (!is_st) tk.ac = alu;
            end
         endcase
      end else if (mode == MODE_D_AC) begin
         tk.pc = {st.y, bval};
      end else if (taken) begin
         tk.pc = (st.pc & PAGE_MASK) | {8'h00, bval};
      end
      tk.ir = rom_instr;
      tk.dr = rom_operand;
   end

   // item kind selects tick or host write
   always_comb begin
      nx               = st;
      flags.hsync_rise = 1'b0;
      flags.vsync_fall = 1'b0;
      wr_en            = 1'b1;
      wr_data          = host_data;
      if (cmd == CMD_TICK) begin
         nx               = tk;
         flags.hsync_rise = !st.out[HSYNC_BIT] && tk.out[HSYNC_BIT];
         flags.vsync_fall = st.out[VSYNC_BIT] && !tk.out[VSYNC_BIT];
         if (flags.hsync_rise) nx.xout = tk.ac;
         wr_en            = is_st && (bus != BUS_RAM);
         wr_data          = bval;
      end
   end

endmodule

// File: rtl/eight_bit_ttl_cpu_cycle_top.sv
// top level of the ttl cpu cycle block: address stage, ram, execute stage, result register
// an accepted item's ram read and fields are registered into the execute stage, where it
//   executes, and its result is registered into the result register when the output does not stall
// throughput: one item per cycle unless the output stalls or the clearing pass runs; the ram
//   read uses x, y, ir and dr forwarded from the executing item; a same-address write is bypassed
// reset: registers clear, then a ram clearing pass over every entry takes no item
module eight_bit_ttl_cpu_cycle_top
   import ttlcpu_pkg::*;
#(
   parameter int RAM_ADDR_BITS = RAM_ADDR_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // rom_instr[7:0], rom_operand[15:8], in_port[23:16], host_addr[39:24], host_data[47:40]
   input  logic [47:0] req_tdata,
   // cmd[0]
   input  logic        req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // fetch_pc[15:0], out_port[23:16], xout_port[31:24], accumulator[39:32],
   // hsync_rise[40], vsync_fall[41], zero[47:42]
   output logic [47:0] rsp_tdata,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data
);

   logic                     mode64_ff;
   logic                     clr_busy_ff;
   logic [RAM_ADDR_BITS-1:0] clr_addr_ff;
   arch_type                 st_ff;
   arch_type                 st_in;
   arch_type                 nx_st;
   arch_type                 cur_st;
   flags_type                nx_flags;

   logic                     s2_valid_ff;
   logic                     s2_cmd_ff;
   logic [7:0]               s2_instr_ff;
   logic [7:0]               s2_data_ff;
   logic [7:0]               s2_inport_ff;
   logic [7:0]               s2_host_data_ff;
   logic [RAM_ADDR_BITS-1:0] s2_addr_ff;
   logic                     byp_valid_ff;
   logic [7:0]               byp_data_ff;

   logic                     out_valid_ff;
   logic [47:0]              out_data_ff;

   logic                     accept;
   logic                     s2_fire;
   logic [15:0]              mask16;
   logic [15:0]              raw_addr;
   logic [15:0]              eff_addr;
   logic [RAM_ADDR_BITS-1:0] rd_addr;
   logic [7:0]               ram_q;
   logic [7:0]               ram_rd;
   logic                     ex_wr_en;
   logic [7:0]               ex_wr_data;
   logic                     wr_en;
   logic [RAM_ADDR_BITS-1:0] wr_addr;
   logic [7:0]               wr_data;

   // handshakes
   assign s2_fire    = s2_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !clr_busy_ff && (!s2_valid_ff || s2_fire);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   // memory mode register
   always_ff @(posedge clock) begin
      if (reset) begin
         mode64_ff <= 1'b0;
      end else if (csr_wr_en) begin
         mode64_ff <= csr_wr_data;
      end
   end

   // clearing pass after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clr_busy_ff) begin
         clr_addr_ff <= clr_addr_ff + 1'b1;
         if (clr_addr_ff == {RAM_ADDR_BITS{1'b1}}) clr_busy_ff <= 1'b0;
      end
   end

   // state as left by the item executing now
   assign cur_st = s2_valid_ff ? nx_st : st_ff;

   // address stage
   assign mask16   = mode64_ff ? MASK_64K : MASK_32K;
   assign raw_addr = (req_tuser == CMD_HOST) ? req_tdata[39:24]
                                             : agen(cur_st.ir, cur_st.dr, cur_st.x, cur_st.y);
   assign eff_addr = raw_addr & mask16;
   assign rd_addr  = eff_addr[RAM_ADDR_BITS-1:0];

   // ram write port: clearing pass or executing item
   assign wr_en   = clr_busy_ff || (s2_fire && ex_wr_en);
   assign wr_addr = clr_busy_ff ? clr_addr_ff : s2_addr_ff;
   assign wr_data = clr_busy_ff ? 8'h00 : ex_wr_data;

   ttlcpu_ram #(
      .ADDR_BITS (RAM_ADDR_BITS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   // execute stage item register
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= accept || (s2_valid_ff && !s2_fire);
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s2_cmd_ff       <= req_tuser;
         s2_instr_ff     <= req_tdata[7:0];
         s2_data_ff      <= req_tdata[15:8];
         s2_inport_ff    <= req_tdata[23:16];
         s2_host_data_ff <= req_tdata[47:40];
         s2_addr_ff      <= rd_addr;
         byp_valid_ff    <= wr_en && (wr_addr == rd_addr);
         byp_data_ff     <= wr_data;
      end
   end

   // write-to-read bypass for the same entry
   assign ram_rd = byp_valid_ff ? byp_data_ff : ram_q;

   ttlcpu_exec u_exec (
      .st          (st_ff),
      .cmd         (s2_cmd_ff),
      .rom_instr   (s2_instr_ff),
      .rom_operand (s2_data_ff),
      .in_port     (s2_inport_ff),
      .host_data   (s2_host_data_ff),
      .ram_rd      (ram_rd),
      .nx          (nx_st),
      .flags       (nx_flags),
      .wr_en       (ex_wr_en),
      .wr_data     (ex_wr_data)
   );

   // architectural registers
   assign st_in = s2_fire ? nx_st : st_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= '0;
      end else begin
         st_ff <= st_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (s2_fire) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_fire) begin
         out_data_ff <= {6'b0, nx_flags.vsync_fall, nx_flags.hsync_rise, nx_st.ac,
                         nx_st.xout, nx_st.out, nx_st.pc};
      end
   end

   // checks
   a_no_accept_while_clearing: assert property (@(posedge clock) disable iff (reset)
      clr_busy_ff |-> !accept)
      else $error("item accepted during ram clearing pass");

   a_host_write_keeps_state: assert property (@(posedge clock) disable iff (reset)
      (s2_fire && s2_cmd_ff == CMD_HOST) |=> st_ff == $past(st_ff))
      else $error("host write changed cpu registers");

   a_hsync_latches_xout: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[40]) |-> (rsp_tdata[31:24] == rsp_tdata[39:32]
                                         && rsp_tdata[22]))
      else $error("hsync rise without xout latch of ac");

   a_vsync_fall_out_low: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[41]) |-> !rsp_tdata[23])
      else $error("vsync fall with out bit 7 still set");

endmodule
